// ===== hdl/b3lut_pkg.sv =====
// Shared types and constants for the binary 3x3 lookup-table filter.
// Used by every module of the block but b3lut_ram; depends on nothing.
`timescale 1ns / 1ps

package b3lut_pkg;

  // Frame geometry
  localparam int FRAME_WIDTH  = 32;
  localparam int FRAME_HEIGHT = 32;

  localparam int COL_W = $clog2(FRAME_WIDTH);
  // One extra row code marks the flush pass over the last row
  localparam int ROW_W = $clog2(FRAME_HEIGHT + 1);

  localparam logic [COL_W-1:0] COL_FIRST = '0;
  localparam logic [COL_W-1:0] COL_LAST  = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_FIRST = '0;
  localparam logic [ROW_W-1:0] ROW_FLUSH = ROW_W'(FRAME_HEIGHT);
  // Rows below this one have their upper neighbor row outside the frame
  localparam logic [ROW_W-1:0] ROW_TOP_IN_FRAME = ROW_W'(2);

  // Lookup table: 8 config words of 64 entries each
  localparam int TABLE_WORDS  = 8;
  localparam int WORD_W       = 64;
  localparam int TABLE_SIZE   = TABLE_WORDS * WORD_W;
  localparam int TABLE_IDX_W  = $clog2(TABLE_SIZE);
  localparam int WORD_SEL_W   = $clog2(TABLE_WORDS);
  localparam int BIT_SEL_W    = $clog2(WORD_W);
  localparam int CFG_IDX_W    = 4;

  localparam logic [TABLE_IDX_W-1:0] IDX_ALL_DARK = '0;
  localparam logic [TABLE_IDX_W-1:0] IDX_ALL_LIT  = TABLE_IDX_W'(TABLE_SIZE - 1);

  // Lit counter
  localparam int              LIT_W   = 11;
  localparam logic [LIT_W-1:0] LIT_MAX = '1;

  // Line buffer entry: {pixel two rows up, pixel one row up}
  localparam int LB_W = 2;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             pix;
  } lb_item_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
  } lb_rd_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [LB_W-1:0]  data;
  } lb_wr_t;

  // One window column, top to bottom
  typedef struct packed {
    logic top;
    logic mid;
    logic bot;
  } win_col_t;

endpackage

// ===== hdl/b3lut_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module b3lut_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/b3lut_table.sv =====
// Lookup table registers with the configuration write port and two read taps.
// Depends on b3lut_pkg.
`timescale 1ns / 1ps

module b3lut_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [b3lut_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [b3lut_pkg::WORD_W-1:0]        cfg_data,
  input  logic [b3lut_pkg::TABLE_IDX_W-1:0]   lookup_idx,
  output logic                                lookup_bit,
  input  logic                                bg,
  output logic                                bg_bit
);

  logic [b3lut_pkg::WORD_W-1:0] words_r [b3lut_pkg::TABLE_WORDS];
  logic [b3lut_pkg::TABLE_IDX_W-1:0] bg_idx;

  // Config writes; indexes past the table are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < b3lut_pkg::TABLE_WORDS; i++) begin
        words_r[i] <= '0;
      end
    end else if (cfg_wr_en &&
                 (cfg_index < b3lut_pkg::CFG_IDX_W'(b3lut_pkg::TABLE_WORDS))) begin
      words_r[cfg_index[b3lut_pkg::WORD_SEL_W-1:0]] <= cfg_data;
    end
  end

  // Neighborhood lookup
  assign lookup_bit =
    words_r[lookup_idx[b3lut_pkg::TABLE_IDX_W-1 -: b3lut_pkg::WORD_SEL_W]]
           [lookup_idx[b3lut_pkg::BIT_SEL_W-1:0]];

  // Background successor: entry of an all-dark or all-lit window
  assign bg_idx = bg ? b3lut_pkg::IDX_ALL_LIT : b3lut_pkg::IDX_ALL_DARK;
  assign bg_bit =
    words_r[bg_idx[b3lut_pkg::TABLE_IDX_W-1 -: b3lut_pkg::WORD_SEL_W]]
           [bg_idx[b3lut_pkg::BIT_SEL_W-1:0]];

endmodule

// ===== hdl/b3lut_seq.sv =====
// Raster position sequencer: accepts input items, runs the last-row flush pass,
// and issues line buffer reads. Depends on b3lut_pkg.
`timescale 1ns / 1ps

module b3lut_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_pixel_in,
  input  logic                s1_ready,
  output logic                ld,
  output b3lut_pkg::lb_item_t ld_item,
  output b3lut_pkg::lb_rd_t   rd
);

  logic [b3lut_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [b3lut_pkg::COL_W-1:0] col_r, col_nxt;
  logic                        flushing;

  assign flushing = (row_r == b3lut_pkg::ROW_FLUSH);
  assign in_ready = s1_ready && !flushing;
  assign ld       = s1_ready && (flushing || in_valid);

  // Item handed to the column stage, with its line buffer read
  assign ld_item.row = row_r;
  assign ld_item.col = col_r;
  assign ld_item.pix = flushing ? 1'b0 : in_pixel_in;
  assign rd.en       = ld;
  assign rd.addr     = col_r;

  // Position advance
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (ld) begin
      if (col_r == b3lut_pkg::COL_LAST) begin
        col_nxt = b3lut_pkg::COL_FIRST;
        row_nxt = flushing ? b3lut_pkg::ROW_FIRST : row_r + b3lut_pkg::ROW_W'(1);
      end else begin
        col_nxt = col_r + b3lut_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= b3lut_pkg::ROW_FIRST;
      col_r <= b3lut_pkg::COL_FIRST;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// ===== hdl/b3lut_emit.sv =====
// Column stage: line buffer write-back, 3x3 window, table index, lit count,
// background tracking and the output register. Depends on b3lut_pkg.
`timescale 1ns / 1ps

module b3lut_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                ld,
  input  b3lut_pkg::lb_item_t                 ld_item,
  output logic                                s1_ready,
  input  logic [b3lut_pkg::LB_W-1:0]          rdata,
  output b3lut_pkg::lb_wr_t                   wr,
  output logic [b3lut_pkg::TABLE_IDX_W-1:0]   tbl_idx,
  input  logic                                tbl_bit,
  output logic                                bg,
  input  logic                                bg_bit,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_pixel_out,
  output logic                                out_frame_done,
  output logic [b3lut_pkg::LIT_W-1:0]         out_lit_total,
  output logic                                out_next_background
);

  // Column stage item and window
  logic                       s1_valid_r, s1_valid_nxt;
  b3lut_pkg::lb_item_t        s1_r;
  b3lut_pkg::win_col_t        win_a_r, win_a_nxt;
  b3lut_pkg::win_col_t        win_b_r, win_b_nxt;
  logic                       tail_r, tail_nxt;
  logic                       tail_last_r, tail_last_nxt;
  logic                       bg_r, bg_nxt;
  logic [b3lut_pkg::LIT_W-1:0] lit_r, lit_nxt, lit_inc;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_pix_r, out_done_r, out_nbg_r;
  logic [b3lut_pkg::LIT_W-1:0] out_lit_r;

  logic                 out_free;
  logic                 s1_fire;
  logic                 emit_go;
  logic                 emit_last;
  logic                 emits_main;
  logic                 tail_needed;
  b3lut_pkg::win_col_t  new_col;
  b3lut_pkg::win_col_t  bg_col;

  function automatic logic [b3lut_pkg::TABLE_IDX_W-1:0] make_idx(
    input b3lut_pkg::win_col_t l,
    input b3lut_pkg::win_col_t m,
    input b3lut_pkg::win_col_t r
  );
    make_idx = {l.top, m.top, r.top, l.mid, m.mid, r.mid, l.bot, m.bot, r.bot};
  endfunction

  assign bg       = bg_r;
  assign out_free = !out_valid_r || out_ready;
  assign bg_col   = '{top: bg_r, mid: bg_r, bot: bg_r};

  // Incoming column: rows outside the frame read as background
  assign new_col.top = (s1_r.row < b3lut_pkg::ROW_TOP_IN_FRAME) ? bg_r : rdata[1];
  assign new_col.mid = rdata[0];
  assign new_col.bot = (s1_r.row == b3lut_pkg::ROW_FLUSH) ? bg_r : s1_r.pix;

  assign emits_main  = (s1_r.row != b3lut_pkg::ROW_FIRST) &&
                       (s1_r.col != b3lut_pkg::COL_FIRST);
  assign tail_needed = (s1_r.row != b3lut_pkg::ROW_FIRST) &&
                       (s1_r.col == b3lut_pkg::COL_LAST);

  // Emit control: a pending right-edge item goes ahead of the next column
  always_comb begin
    s1_fire   = 1'b0;
    emit_go   = 1'b0;
    emit_last = 1'b0;
    tbl_idx   = make_idx(win_a_r, win_b_r, new_col);
    if (tail_r) begin
      emit_go   = out_free;
      emit_last = tail_last_r;
      tbl_idx   = make_idx(win_a_r, win_b_r, bg_col);
    end else if (s1_valid_r) begin
      s1_fire = !emits_main || out_free;
      emit_go = emits_main && out_free;
    end
  end

  assign s1_ready = !s1_valid_r || s1_fire;

  // Line buffer write-back: shift this row's pixel into the entry
  assign wr.en   = s1_fire && (s1_r.row != b3lut_pkg::ROW_FLUSH);
  assign wr.addr = s1_r.col;
  assign wr.data = {rdata[0], s1_r.pix};

  // Lit count with saturation
  assign lit_inc = (tbl_bit && (lit_r != b3lut_pkg::LIT_MAX)) ?
                   lit_r + b3lut_pkg::LIT_W'(1) : lit_r;

  // Stage, window, tail and frame state
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    win_a_nxt     = win_a_r;
    win_b_nxt     = win_b_r;
    tail_nxt      = tail_r;
    tail_last_nxt = tail_last_r;
    bg_nxt        = bg_r;
    lit_nxt       = lit_r;
    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
      if (s1_r.col == b3lut_pkg::COL_FIRST) begin
        win_a_nxt = bg_col;
      end else begin
        win_a_nxt = win_b_r;
      end
      win_b_nxt     = new_col;
      tail_nxt      = tail_needed;
      tail_last_nxt = (s1_r.row == b3lut_pkg::ROW_FLUSH);
    end
    if (ld) begin
      s1_valid_nxt = 1'b1;
    end
    if (tail_r && emit_go) begin
      tail_nxt = 1'b0;
    end
    if (emit_go) begin
      if (emit_last) begin
        lit_nxt = '0;
        bg_nxt  = bg_bit;
      end else begin
        lit_nxt = lit_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      tail_r      <= 1'b0;
      tail_last_r <= 1'b0;
      bg_r        <= 1'b0;
      lit_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      tail_r      <= tail_nxt;
      tail_last_r <= tail_last_nxt;
      bg_r        <= bg_nxt;
      lit_r       <= lit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      s1_r <= ld_item;
    end
    win_a_r <= win_a_nxt;
    win_b_r <= win_b_nxt;
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_pix_r  <= tbl_bit;
      out_done_r <= emit_last;
      out_lit_r  <= emit_last ? lit_inc : '0;
      out_nbg_r  <= bg_bit;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pixel_out       = out_pix_r;
  assign out_frame_done      = out_done_r;
  assign out_lit_total       = out_lit_r;
  assign out_next_background = out_nbg_r;

endmodule

// ===== hdl/binary_3x3_lut_filter_core.sv =====
// Top level of the binary 3x3 lookup-table filter: sequencer, line buffer RAM,
// table registers and column stage. Depends on b3lut_pkg and all b3lut modules.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-------------------
//   input   | in_pixel_in                             | in_valid/in_ready
//   result  | out_pixel_out, out_frame_done,          | out_valid/out_ready
//           | out_lit_total, out_next_background      |
//   config  | cfg_index, cfg_data                     | cfg_wr_en
//
// One pixel is taken per clock, except in the stalls below. A right-edge result (each row
// end but the first, and the end of the flush) takes its own slot, so the next input
// waits. After the last pixel of a frame in_ready stays low while the last row is flushed
// from the line buffer. The single result port (one item per clock while out_ready is
// high) causes the stalls. Items are registered in the column stage, results in the output
// register. Reset needs no clearing pass; rows outside the frame read as background.
`timescale 1ns / 1ps

module binary_3x3_lut_filter_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_pixel_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_pixel_out,
  output logic                              out_frame_done,
  output logic [b3lut_pkg::LIT_W-1:0]       out_lit_total,
  output logic                              out_next_background,
  input  logic                              cfg_wr_en,
  input  logic [b3lut_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [b3lut_pkg::WORD_W-1:0]      cfg_data
);

  logic                               s1_ready;
  logic                               ld;
  b3lut_pkg::lb_item_t                ld_item;
  b3lut_pkg::lb_rd_t                  rd;
  b3lut_pkg::lb_wr_t                  wr;
  logic [b3lut_pkg::LB_W-1:0]         rdata;
  logic [b3lut_pkg::TABLE_IDX_W-1:0]  tbl_idx;
  logic                               tbl_bit;
  logic                               bg;
  logic                               bg_bit;

  // Raster position and flush pass
  b3lut_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pixel_in (in_pixel_in),
    .s1_ready    (s1_ready),
    .ld          (ld),
    .ld_item     (ld_item),
    .rd          (rd)
  );

  // Line buffer: two previous rows per column
  b3lut_ram #(
    .WIDTH (b3lut_pkg::LB_W),
    .DEPTH (b3lut_pkg::FRAME_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (rdata)
  );

  // Lookup table
  b3lut_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .lookup_idx (tbl_idx),
    .lookup_bit (tbl_bit),
    .bg         (bg),
    .bg_bit     (bg_bit)
  );

  // Window, count and output register
  b3lut_emit u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ld                  (ld),
    .ld_item             (ld_item),
    .s1_ready            (s1_ready),
    .rdata               (rdata),
    .wr                  (wr),
    .tbl_idx             (tbl_idx),
    .tbl_bit             (tbl_bit),
    .bg                  (bg),
    .bg_bit              (bg_bit),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_pixel_out       (out_pixel_out),
    .out_frame_done      (out_frame_done),
    .out_lit_total       (out_lit_total),
    .out_next_background (out_next_background)
  );

endmodule
